@@ rtl/svst_pkg.sv @@
// Package for the voice steal table: sizes, request codes and shared types.
// Depends on nothing.
`default_nettype none
package svst_pkg;
   localparam int VOICES = 32;
   localparam int SLOT_W = $clog2(VOICES);
   localparam int LINK_W = SLOT_W + 1;
   localparam int TIME_W = 63;
   localparam int PRIO_W = 32;
   localparam int ENTRY_W = PRIO_W + 2 + 2 * TIME_W;

   localparam logic [2:0] REQ_INSERT  = 3'd0;
   localparam logic [2:0] REQ_UPDATE  = 3'd1;
   localparam logic [2:0] REQ_RELEASE = 3'd2;
   localparam logic [2:0] REQ_STEAL   = 3'd3;
   localparam logic [2:0] REQ_OLDEST  = 3'd4;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [SLOT_W-1:0] slot;
      logic [PRIO_W-1:0] priority_req;
      logic              note_on;
      logic              tagged_req;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] stop_time;
   } req_type_t_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] chosen_slot;
      logic              misuse;
   } rsp_payload_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic              held;
      logic              slated;
      logic [TIME_W-1:0] began;
      logic [TIME_W-1:0] ended;
   } entry_type;
endpackage
`default_nettype wire

@@ rtl/svst_if.sv @@
// Valid/ready channel interface carrying a request or a response payload.
// Depends on svst_pkg.
`default_nettype none
interface svst_req_if;
   svst_pkg::req_type_t_type data;
   logic valid;
   logic ready;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface svst_rsp_if;
   svst_pkg::rsp_payload_type data;
   logic valid;
   logic ready;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/synth_voice_steal_table.sv @@
// Top level of the voice steal table: sequencer walking the linked list.
// Depends on svst_pkg, svst_if and svst_ram.
//
//   channel  direction  port prefix  beat
//   req      in         req_         one request
//   rsp      out        rsp_         one response per request
//
// Insert, release, steal and oldest walk the list, reading and then evaluating each listed voice.
// An update reads its entry and writes it back.
// An insert walks the list once; a steal that finds a voice walks it twice, to choose and
// then to unlink.
// Reset is synchronous; it clears the in-use bits and empties the list.
// A waiting response holds the sequencer until rsp_ready is seen.
`default_nettype none
module synth_voice_steal_table (
   input wire logic clock,
   input wire logic reset,
   svst_req_if.sink req_ch,
   svst_rsp_if.source rsp_ch
);
   import svst_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;
   localparam logic [2:0] S_RSP  = 3'd5;
   localparam logic [2:0] S_RM   = 3'd6;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(VOICES);

   logic [2:0] state_ff, state_in;
   req_type_t_type rq_ff, rq_in;
   logic [VOICES-1:0] use_ff, use_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LINK_W-1:0] best_ff, best_in, rmprev_ff, rmprev_in;
   logic [LINK_W-1:0] tgt_ff, tgt_in;
   logic [SLOT_W:0] guard_ff, guard_in;
   entry_type best_e_ff, best_e_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic e_we, l_we;
   logic [SLOT_W-1:0] e_wa, l_wa, rd_a;
   entry_type e_wd, e_rd;
   logic [LINK_W-1:0] l_wd, l_rd;

   svst_ram #(.WIDTH(ENTRY_W), .DEPTH(VOICES)) u_entry (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(rd_a), .rd_data(e_rd)
   );
   svst_ram #(.WIDTH(LINK_W), .DEPTH(VOICES)) u_link (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(rd_a), .rd_data(l_rd)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_RSP);
   assign rsp_ch.data  = rsp_ff;

   logic [LINK_W-1:0] nxt;
   logic cand, better, stop_walk;
   entry_type new_e;

   always_comb begin
      state_in = state_ff; rq_in = rq_ff; use_in = use_ff; head_in = head_ff;
      cur_in = cur_ff; prev_in = prev_ff; best_in = best_ff; rmprev_in = rmprev_ff;
      tgt_in = tgt_ff; guard_in = guard_ff;
      best_e_in = best_e_ff; rsp_in = rsp_ff;
      e_we = 1'b0; l_we = 1'b0; e_wa = rq_ff.slot; l_wa = rq_ff.slot;
      l_wd = NIL; rd_a = cur_ff[SLOT_W-1:0];
      new_e.prio = rq_ff.priority_req; new_e.held = rq_ff.note_on;
      new_e.slated = rq_ff.tagged_req; new_e.began = rq_ff.start_time;
      new_e.ended = rq_ff.stop_time;
      e_wd = new_e;
      nxt = (l_rd >= NIL) ? NIL : l_rd;
      stop_walk = (cur_ff >= NIL) || (guard_ff >= (SLOT_W+1)'(VOICES));
      cand = 1'b0; better = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               rq_in = req_ch.data;
               rsp_in = '0; cur_in = head_ff; prev_in = NIL; best_in = NIL;
               guard_in = '0; tgt_in = LINK_W'(req_ch.data.slot);
               state_in = S_RSP;
               case (req_ch.data.req_type)
                  REQ_INSERT: begin
                     if (use_ff[req_ch.data.slot]) rsp_in.misuse = 1'b1;
                     else state_in = S_RD;
                  end
                  REQ_UPDATE: begin
                     cur_in = LINK_W'(req_ch.data.slot);
                     if (!use_ff[req_ch.data.slot]) rsp_in.misuse = 1'b1;
                     else state_in = S_RD;
                  end
                  REQ_RELEASE: begin
                     if (!use_ff[req_ch.data.slot]) rsp_in.misuse = 1'b1;
                     else state_in = S_RD;
                  end
                  REQ_STEAL: state_in = S_RD;
                  REQ_OLDEST: state_in = S_RD;
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_RD: begin
            if (stop_walk) begin
               state_in = S_DONE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_RD; prev_in = cur_ff; cur_in = nxt;
            guard_in = guard_ff + 1'b1;
            case (rq_ff.req_type)
               REQ_UPDATE: begin
                  e_we = 1'b1; e_wd.prio = e_rd.prio; state_in = S_RSP;
               end
               REQ_INSERT: begin
                  if (e_rd.prio > rq_ff.priority_req) begin
                     state_in = S_DONE; cur_in = cur_ff; prev_in = prev_ff;
                  end
               end
               REQ_RELEASE: begin
                  if (cur_ff == tgt_ff) begin
                     rmprev_in = prev_ff; best_in = nxt; state_in = S_FIX;
                  end
               end
               REQ_STEAL: begin
                  cand = (e_rd.prio <= rq_ff.priority_req);
                  if (cand) begin
                     if (best_ff == NIL) better = 1'b1;
                     else if (!e_rd.held)
                        better = best_e_ff.held || (best_e_ff.ended > e_rd.ended);
                     else better = best_e_ff.began > e_rd.began;
                  end
                  if (better) begin
                     best_in = cur_ff; best_e_in = e_rd;
                  end
               end
               default: begin
                  if (best_ff == NIL) begin
                     best_in = cur_ff; best_e_in = e_rd;
                  end else if (!e_rd.slated) begin
                     if (best_e_ff.slated) better = 1'b1;
                     else if (e_rd.prio <= best_e_ff.prio) begin
                        if (e_rd.held)
                           better = best_e_ff.held && (best_e_ff.began > e_rd.began);
                        else
                           better = best_e_ff.held || (best_e_ff.ended < e_rd.ended);
                     end
                     if (better) begin
                        best_in = cur_ff; best_e_in = e_rd;
                     end
                  end
               end
            endcase
         end
         S_DONE: begin
            state_in = S_RSP;
            case (rq_ff.req_type)
               REQ_INSERT: begin
                  e_we = 1'b1; l_we = 1'b1; l_wd = cur_ff;
                  use_in[rq_ff.slot] = 1'b1;
                  if (prev_ff == NIL) head_in = LINK_W'(rq_ff.slot);
                  else state_in = S_FIX;
               end
               REQ_RELEASE: use_in[rq_ff.slot] = 1'b0;
               REQ_STEAL: begin
                  if (best_ff != NIL) begin
                     rsp_in.found = 1'b1; rsp_in.chosen_slot = best_ff[SLOT_W-1:0];
                     tgt_in = best_ff; cur_in = head_ff; prev_in = NIL;
                     guard_in = '0; state_in = S_RM;
                     rq_in.req_type = REQ_RELEASE;
                  end
               end
               default: begin
                  if (best_ff != NIL && !best_e_ff.slated) begin
                     rsp_in.found = 1'b1; rsp_in.chosen_slot = best_ff[SLOT_W-1:0];
                  end
               end
            endcase
         end
         S_RM: state_in = S_RD;
         S_FIX: begin
            state_in = S_RSP; l_we = 1'b1;
            if (rq_ff.req_type == REQ_INSERT) begin
               l_wa = prev_ff[SLOT_W-1:0]; l_wd = LINK_W'(rq_ff.slot);
            end else begin
               use_in[tgt_ff[SLOT_W-1:0]] = 1'b0;
               l_wa = tgt_ff[SLOT_W-1:0]; l_wd = NIL;
               if (rmprev_ff == NIL) begin
                  head_in = best_ff; l_we = 1'b1;
               end else begin
                  l_wa = rmprev_ff[SLOT_W-1:0]; l_wd = best_ff;
               end
            end
         end
         S_RSP: if (rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; use_ff <= '0; head_ff <= NIL;
      end else begin
         state_ff <= state_in; use_ff <= use_in; head_ff <= head_in;
      end
      rq_ff <= rq_in; cur_ff <= cur_in; prev_ff <= prev_in; best_ff <= best_in;
      rmprev_ff <= rmprev_in; tgt_ff <= tgt_in;
      guard_ff <= guard_in; best_e_ff <= best_e_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

@@ rtl/svst_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module svst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/svst_checker.sv @@
// Port-level checker for the voice steal table, bound to the top level.
// Depends on synth_voice_steal_table and its svst_if ports.
`default_nettype none
module svst_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_found,
   input wire logic rsp_misuse,
   input wire logic [4:0] rsp_slot
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready) else $error("no return to idle");
   a_fm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_misuse)) else $error("found with misuse");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_slot == 5'd0) else $error("slot not zero");
endmodule

bind synth_voice_steal_table svst_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_found(rsp_ch.data.found), .rsp_misuse(rsp_ch.data.misuse),
   .rsp_slot(rsp_ch.data.chosen_slot)
);
`default_nettype wire
